@@ design/poolad_pkg.sv @@
// shared types and constants for the pool admission block
// no dependencies; imported by every module of the block

package poolad_pkg;

	localparam int QUEUE_SLOTS = 16;
	localparam int ID_WIDTH    = 10;
	localparam int LEN_W       = $clog2(QUEUE_SLOTS + 1);
	localparam int CNT_W       = 10;
	localparam int FRAC_W      = 9;
	localparam int QLIM_W      = 5;

	typedef enum logic [1:0] {
		FUNC_ACQUIRE  = 2'd0,
		FUNC_RELEASE  = 2'd1,
		FUNC_WITHDRAW = 2'd2,
		FUNC_NONE     = 2'd3
	} func_t;

	typedef enum logic [1:0] {
		OUT_NONE    = 2'd0,
		OUT_GRANT   = 2'd1,
		OUT_REFUSED = 2'd2
	} outcome_t;

	typedef enum logic [1:0] {
		REG_MAX_CONN  = 2'd0,
		REG_RESERVE   = 2'd1,
		REG_QUEUE_LIM = 2'd2,
		REG_IDLE_LIM  = 2'd3
	} reg_idx_t;

	// control broadcast to every cell of the waiter chain
	typedef struct packed {
		logic                by_prio;
		logic [ID_WIDTH-1:0] key;
		logic                drop_first;
		logic                drop_head;
		logic [ID_WIDTH-1:0] new_id;
		logic                new_prio;
	} cell_ctl_t;

endpackage

@@ design/poolad_cell.sv @@
// one waiter slot of the queue chain: holds an id and a priority mark
// depends on poolad_pkg

module poolad_cell import poolad_pkg::*; (
	input  logic                clk,
	input  cell_ctl_t           ctl,
	input  logic                occ,
	input  logic                load,
	input  logic [ID_WIDTH-1:0] nb_id,
	input  logic                nb_prio,
	input  logic                found_in,
	input  logic [ID_WIDTH-1:0] sel_in,
	output logic                found_out,
	output logic [ID_WIDTH-1:0] sel_out,
	output logic [ID_WIDTH-1:0] id_out,
	output logic                prio_out
);

	logic [ID_WIDTH-1:0] id_q;
	logic                prio_q;
	logic                hit;
	logic                shift;

	assign hit       = occ & (ctl.by_prio ? prio_q : (id_q == ctl.key));
	assign found_out = found_in | hit;
	assign sel_out   = (found_in | ~hit) ? sel_in : id_q;
	// every slot at or behind the removed one pulls from its right neighbor
	assign shift     = (ctl.drop_first & found_out) | ctl.drop_head;
	assign id_out    = id_q;
	assign prio_out  = prio_q;

	always_ff @(posedge clk) begin
		if (load) begin
			id_q   <= ctl.new_id;
			prio_q <= ctl.new_prio;
		end else if (shift) begin
			id_q   <= nb_id;
			prio_q <= nb_prio;
		end
	end

endmodule

@@ design/poolad_chain.sv @@
// ordered waiter queue built as a row of poolad_cell slots
// depends on poolad_pkg and poolad_cell

module poolad_chain import poolad_pkg::*; (
	input  logic                clk,
	input  cell_ctl_t           ctl,
	input  logic [LEN_W-1:0]    len,
	input  logic                append,
	output logic                found_any,
	output logic [ID_WIDTH-1:0] sel_id,
	output logic [ID_WIDTH-1:0] head_id
);

	logic [QUEUE_SLOTS:0]                found;
	logic [QUEUE_SLOTS:0][ID_WIDTH-1:0]  sel;
	logic [QUEUE_SLOTS:0][ID_WIDTH-1:0]  ids;
	logic [QUEUE_SLOTS:0]                prios;

	assign found[0]           = 1'b0;
	assign sel[0]             = '0;
	assign ids[QUEUE_SLOTS]   = '0;
	assign prios[QUEUE_SLOTS] = 1'b0;

	for (genvar i = 0; i < QUEUE_SLOTS; i++) begin : g_slot
		logic occ;
		logic load;

		assign occ  = LEN_W'(i) < len;
		assign load = append & (len == LEN_W'(i));

		poolad_cell u_cell (
			.clk      (clk),
			.ctl      (ctl),
			.occ      (occ),
			.load     (load),
			.nb_id    (ids[i+1]),
			.nb_prio  (prios[i+1]),
			.found_in (found[i]),
			.sel_in   (sel[i]),
			.found_out(found[i+1]),
			.sel_out  (sel[i+1]),
			.id_out   (ids[i]),
			.prio_out (prios[i])
		);
	end

	assign found_any = found[QUEUE_SLOTS];
	assign sel_id    = sel[QUEUE_SLOTS];
	assign head_id   = ids[0];

endmodule

@@ design/pool_admission_with_priority_reserve.sv @@
// top level of the pool admission block: config registers, counters, control
// depends on poolad_pkg and poolad_chain
// result strobe (done) is registered in ST_EXEC, the state entered at the accepting edge
// one item at a time: start is taken only in ST_IDLE; the queue search runs through the cell chain
// combinationally in ST_EXEC, busy covers that state. results cannot be stalled by the receiver.
// reset: counters and queue length clear, registers load 16 / 0 / 16 / 8

module pool_admission_with_priority_reserve import poolad_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  logic [1:0]          func,
	input  logic [ID_WIDTH-1:0] request_id,
	input  logic                is_priority,
	input  logic                conn_open,
	output logic                done,
	output logic [1:0]          outcome,
	output logic [ID_WIDTH-1:0] granted_id,
	output logic                reused,
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [3:0]          paddr,
	input  logic [31:0]         pwdata,
	output logic [31:0]         prdata,
	output logic                pready
);

	localparam int CAP_W  = (LEN_W > QLIM_W) ? LEN_W : QLIM_W;
	localparam int PROD_W = CNT_W + FRAC_W;

	typedef enum logic {ST_IDLE, ST_EXEC} state_t;

	state_t state_q;

	logic [CNT_W-1:0]  max_q;
	logic [FRAC_W-1:0] frac_q;
	logic [QLIM_W-1:0] qlim_q;
	logic [CNT_W-1:0]  idle_lim_q;
	logic [CNT_W-1:0]  lim_norm;

	logic [CNT_W-1:0]    active_q;
	logic [CNT_W-1:0]    idle_q;
	logic [LEN_W-1:0]    len_q;
	func_t               func_q;
	logic [ID_WIDTH-1:0] id_q;
	logic                prio_q;
	logic                open_q;

	logic                done_q;
	outcome_t            outcome_q;
	logic [ID_WIDTH-1:0] gid_q;
	logic                reused_q;

	logic                cfg_wr;
	reg_idx_t            cfg_idx;
	logic [PROD_W-1:0]   prod;
	logic [CNT_W:0]      kept;

	cell_ctl_t           ctl;
	logic                append;
	logic                found_any;
	logic [ID_WIDTH-1:0] sel_id;
	logic [ID_WIDTH-1:0] head_id;

	logic [CAP_W-1:0]    cap;
	logic                full;
	logic [CNT_W-1:0]    act_rel;
	logic [CNT_W-1:0]    idle_rel;
	logic [CNT_W-1:0]    act_base;
	logic [CNT_W-1:0]    idle_base;
	logic                do_give;
	logic [ID_WIDTH-1:0] give_id;
	logic                refuse;
	logic                give_reused;
	logic [CNT_W-1:0]    act_next;
	logic [CNT_W-1:0]    idle_next;
	logic [LEN_W-1:0]    len_next;

	// config port
	assign pready  = 1'b1;
	assign cfg_wr  = psel & penable & pwrite;
	assign cfg_idx = reg_idx_t'(paddr[3:2]);

	always_comb begin
		case (cfg_idx)
			REG_MAX_CONN:  prdata = 32'(max_q);
			REG_RESERVE:   prdata = 32'(frac_q);
			REG_QUEUE_LIM: prdata = 32'(qlim_q);
			REG_IDLE_LIM:  prdata = 32'(idle_lim_q);
			default:       prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_q      <= CNT_W'(16);
			frac_q     <= '0;
			qlim_q     <= QLIM_W'(16);
			idle_lim_q <= CNT_W'(8);
		end else if (cfg_wr) begin
			case (cfg_idx)
				REG_MAX_CONN:  max_q      <= pwdata[CNT_W-1:0];
				REG_RESERVE:   frac_q     <= pwdata[FRAC_W-1:0];
				REG_QUEUE_LIM: qlim_q     <= pwdata[QLIM_W-1:0];
				REG_IDLE_LIM:  idle_lim_q <= pwdata[CNT_W-1:0];
				default: ;
			endcase
		end
	end

	// normal limit, max minus the reserved share
	assign prod = PROD_W'(max_q) * PROD_W'(frac_q);
	assign kept = prod[PROD_W-1:8];

	assign lim_norm = ({1'b0, max_q} > kept) ? (max_q - kept[CNT_W-1:0]) : '0;

	// decision for the item in flight
	assign cap  = (CAP_W'(qlim_q) < CAP_W'(QUEUE_SLOTS)) ? CAP_W'(qlim_q)
	                                                      : CAP_W'(QUEUE_SLOTS);
	assign full = CAP_W'(len_q) >= cap;

	assign act_rel  = (active_q == '0) ? '0 : active_q - CNT_W'(1);
	assign idle_rel = (open_q && idle_q < idle_lim_q) ? idle_q + CNT_W'(1) : idle_q;

	always_comb begin
		ctl.by_prio    = (func_q == FUNC_RELEASE);
		ctl.key        = id_q;
		ctl.drop_first = 1'b0;
		ctl.drop_head  = 1'b0;
		ctl.new_id     = id_q;
		ctl.new_prio   = prio_q;
		append         = 1'b0;
		do_give        = 1'b0;
		give_id        = id_q;
		refuse         = 1'b0;
		act_base       = active_q;
		idle_base      = idle_q;
		if (state_q == ST_EXEC) begin
			case (func_q)
				FUNC_ACQUIRE: begin
					if (active_q < (prio_q ? max_q : lim_norm)) begin
						do_give = 1'b1;
					end else if (full) begin
						refuse = 1'b1;
					end else begin
						append = 1'b1;
					end
				end
				FUNC_RELEASE: begin
					act_base  = act_rel;
					idle_base = idle_rel;
					// a waiting priority request blocks the normal-limit path
					if (found_any) begin
						if (act_rel < max_q) begin
							do_give        = 1'b1;
							give_id        = sel_id;
							ctl.drop_first = 1'b1;
						end
					end else if (len_q != '0 && act_rel < lim_norm) begin
						do_give       = 1'b1;
						give_id       = head_id;
						ctl.drop_head = 1'b1;
					end
				end
				FUNC_WITHDRAW: begin
					ctl.drop_first = found_any;
				end
				default: ;
			endcase
		end
	end

	assign give_reused = do_give & (idle_base != '0);
	assign act_next    = do_give ? act_base + CNT_W'(1) : act_base;
	assign idle_next   = give_reused ? idle_base - CNT_W'(1) : idle_base;

	always_comb begin
		len_next = len_q;
		if (append) begin
			len_next = len_q + LEN_W'(1);
		end else if (ctl.drop_first || ctl.drop_head) begin
			len_next = len_q - LEN_W'(1);
		end
	end

	poolad_chain u_chain (
		.clk      (clk),
		.ctl      (ctl),
		.len      (len_q),
		.append   (append),
		.found_any(found_any),
		.sel_id   (sel_id),
		.head_id  (head_id)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			active_q  <= '0;
			idle_q    <= '0;
			len_q     <= '0;
			done_q    <= 1'b0;
			outcome_q <= OUT_NONE;
			gid_q     <= '0;
			reused_q  <= 1'b0;
			func_q    <= FUNC_NONE;
			id_q      <= '0;
			prio_q    <= 1'b0;
			open_q    <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (start) begin
						func_q  <= func_t'(func);
						id_q    <= request_id;
						prio_q  <= is_priority;
						open_q  <= conn_open;
						state_q <= ST_EXEC;
					end
				end
				ST_EXEC: begin
					active_q <= act_next;
					idle_q   <= idle_next;
					len_q    <= len_next;
					done_q   <= 1'b1;
					reused_q <= give_reused;
					if (do_give) begin
						outcome_q <= OUT_GRANT;
						gid_q     <= give_id;
					end else if (refuse) begin
						outcome_q <= OUT_REFUSED;
						gid_q     <= id_q;
					end else begin
						outcome_q <= OUT_NONE;
						gid_q     <= '0;
					end
					state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign busy       = (state_q != ST_IDLE);
	assign done       = done_q;
	assign outcome    = outcome_q;
	assign granted_id = gid_q;
	assign reused     = reused_q;

	// an accepted beat is worked on in a single ST_EXEC state; in the next cycle busy is low and done is high
	a_exec_one: assert property (@(posedge clk) disable iff (!arst_n)
		busy |=> (!busy && done))
		else $error("exec did not finish in one cycle");

	a_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("accepted beat did not start work");

	a_reuse_grant: assert property (@(posedge clk) disable iff (!arst_n)
		(done && outcome != OUT_GRANT) |-> !reused)
		else $error("reused flag without a grant");

	a_len_bound: assert property (@(posedge clk) disable iff (!arst_n)
		CAP_W'(len_q) <= CAP_W'(QUEUE_SLOTS))
		else $error("queue length beyond slot count");

	a_refuse_full: assert property (@(posedge clk) disable iff (!arst_n)
		(busy && refuse) |-> full)
		else $error("refusal with room in queue");

endmodule
